// ===== rtl/core/pth_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pth_pkg
// Shared types and constants of the periodic timer heap core.
// ----------------------------------------------------------------------------
package pth_pkg;
	localparam int HeapDepth = 8;
	localparam int IdxW = $clog2(HeapDepth);
	localparam int CntW = $clog2(HeapDepth + 1);
	localparam int MaxExp = 8;
	localparam int ExpW = $clog2(MaxExp + 1);

	localparam logic [1:0] KIND_ACCEPT  = 2'd0;
	localparam logic [1:0] KIND_FULL    = 2'd1;
	localparam logic [1:0] KIND_EXPIRED = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic add;       // write new entry at count, bump id
		logic tick;      // advance tick counter
		logic scan_clr;  // start search at entry 0
		logic scan_step; // compare entry at scan index, advance
		logic rearm;     // rewrite best entry
		logic load_out;  // capture result
		logic [1:0] kind;
		logic last;
	} pth_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic scan_end;  // scan index reached count
		logic best_due;
	} pth_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/periodic_timer_heap_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_heap_core
// Queue of up to eight periodic timers, popped in deadline order on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one transfer per request. tuser = req_type (0 add, 1 tick),
//   tdata = interval (add period, 0 taken as 1; ignored on a tick).
//   m_axis: result transfers. tdata[1:0] result_kind, tdata[17:2] timer_num;
//   tlast marks the final result of the request.
// Sequencing:
//   add: result registered the cycle after acceptance, one result.
//   tick: each expiry takes a decide state plus one linear search over the
//   held timers through the single comparator, plus a result handover;
//   up to 8 expiries then tick-done. One request in flight at a time:
//   s_axis_tready is low from acceptance until the last result is taken.
// Reset: arst_n clears the timer count, tick and id counters; stored
//   entries are not cleared, only entries below the count are read.
// Stall: a held result waits in the output register with tvalid high;
//   the sequencer does not move until m_axis_tready takes it.
// ----------------------------------------------------------------------------
module periodic_timer_heap_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] interval
	input  wire logic        s_axis_tuser,  // [0] req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [1:0] result_kind, [17:2] timer_num
	output logic             m_axis_tlast
);
	import pth_pkg::*;

	pth_cmd_t cmd;
	pth_sts_t sts;
	logic [1:0] kind;
	logic [15:0] tid;

	pth_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_req(s_axis_tuser), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	pth_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_interval(s_axis_tdata),
		.cmd(cmd), .sts(sts),
		.res_kind_q(kind), .res_id_q(tid), .res_last_q(m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, tid, kind};

	// no new request while a result is still pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("request accepted with result pending");
	// add results always close the request
	a_add_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (kind == KIND_ACCEPT || kind == KIND_FULL)) |-> m_axis_tlast)
		else $error("add result without tlast");
	// expiry never marked last
	a_exp_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && kind == KIND_EXPIRED) |-> !m_axis_tlast)
		else $error("expiry marked last");
endmodule
`default_nettype wire

// ===== rtl/core/pth_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pth_datapath
// Timer store, tick and id counters, sequential minimum search, result reg.
// ----------------------------------------------------------------------------
module pth_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [15:0]     in_interval,
	input  wire pth_pkg::pth_cmd_t cmd,
	output pth_pkg::pth_sts_t    sts,
	output logic [1:0]           res_kind_q,
	output logic [15:0]          res_id_q,
	output logic                 res_last_q
);
	import pth_pkg::*;

	logic [31:0] dl_q [HeapDepth];
	logic [15:0] iv_q [HeapDepth];
	logic [15:0] id_q [HeapDepth];
	logic [CntW-1:0] count_q;
	logic [31:0] tick_q;
	logic [15:0] next_id_q;
	logic [CntW-1:0] scan_q;
	logic [IdxW-1:0] best_q;
	logic [31:0] best_rel_q;
	logic [15:0] best_id_q;
	logic [15:0] iv_eff;
	logic [31:0] cand_rel;
	logic cand_better;
	logic [IdxW-1:0] scan_idx;

	assign iv_eff = (in_interval == 16'd0) ? 16'd1 : in_interval;
	assign scan_idx = scan_q[IdxW-1:0];
	assign cand_rel = dl_q[scan_idx] - tick_q;
	assign cand_better = ($signed(cand_rel) < $signed(best_rel_q)) ||
		((cand_rel == best_rel_q) && (id_q[scan_idx] < best_id_q));

	assign sts.full = (count_q >= CntW'(HeapDepth));
	assign sts.empty = (count_q == '0);
	assign sts.scan_end = (scan_q >= count_q);
	assign sts.best_due = ($signed(best_rel_q) <= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tick_q <= '0;
			next_id_q <= '0;
		end else begin
			if (cmd.add) begin
				count_q <= count_q + 1'b1;
				next_id_q <= next_id_q + 16'd1;
			end
			if (cmd.tick)
				tick_q <= tick_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			dl_q[count_q[IdxW-1:0]] <= tick_q + {16'd0, iv_eff};
			iv_q[count_q[IdxW-1:0]] <= iv_eff;
			id_q[count_q[IdxW-1:0]] <= next_id_q;
		end
		if (cmd.rearm)
			dl_q[best_q] <= tick_q + {16'd0, iv_q[best_q]};
		if (cmd.scan_clr) begin
			scan_q <= CntW'(1);
			best_q <= '0;
			best_rel_q <= dl_q[0] - tick_q;
			best_id_q <= id_q[0];
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (cand_better) begin
				best_q <= scan_idx;
				best_rel_q <= cand_rel;
				best_id_q <= id_q[scan_idx];
			end
		end
		if (cmd.load_out) begin
			res_kind_q <= cmd.kind;
			res_last_q <= cmd.last;
			unique case (cmd.kind)
				KIND_ACCEPT:  res_id_q <= next_id_q;
				KIND_EXPIRED: res_id_q <= best_id_q;
				default:      res_id_q <= 16'd0;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/pth_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pth_ctrl
// Sequencer: input handshake, scan loop, result handshake.
// ----------------------------------------------------------------------------
module pth_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_req,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire pth_pkg::pth_sts_t sts,
	output pth_pkg::pth_cmd_t  cmd
);
	import pth_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;
	localparam logic [2:0] S_OUTL = 3'd4;

	logic [2:0] state_q, state_d;
	logic [ExpW-1:0] nexp_q;
	logic tick_go, ovalid_q;

	assign in_ready = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign tick_go = in_valid && in_ready && (in_req == REQ_TICK);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					if (in_req == REQ_TICK) begin
						cmd.tick = 1'b1;
						state_d = S_DEC;
					end else begin
						cmd.load_out = 1'b1;
						cmd.last = 1'b1;
						cmd.kind = sts.full ? KIND_FULL : KIND_ACCEPT;
						cmd.add = !sts.full;
						state_d = S_OUTL;
					end
				end
			end
			S_DEC: begin
				// decide: more expiries allowed and heap non-empty -> search
				if (sts.empty || nexp_q == ExpW'(MaxExp)) begin
					cmd.load_out = 1'b1;
					cmd.kind = KIND_DONE;
					cmd.last = 1'b1;
					state_d = S_OUTL;
				end else begin
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!sts.scan_end) begin
					cmd.scan_step = 1'b1;
				end else if (sts.best_due) begin
					cmd.load_out = 1'b1;
					cmd.kind = KIND_EXPIRED;
					cmd.rearm = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.load_out = 1'b1;
					cmd.kind = KIND_DONE;
					cmd.last = 1'b1;
					state_d = S_OUTL;
				end
			end
			S_OUT: if (out_ready) state_d = S_DEC;
			S_OUTL: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nexp_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tick_go)
				nexp_q <= '0;
			else if (cmd.rearm)
				nexp_q <= nexp_q + 1'b1;
			if (cmd.load_out)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks periodic_timer_heap_core against a behavioural timer queue: adds and
// ticks go in on s_axis with random gaps, every result transfer on m_axis is
// compared field by field with the queue's predicted results, in order.
// ----------------------------------------------------------------------------
import pth_pkg::*;

typedef struct packed {
	logic [1:0]  kind;
	logic [15:0] id;
	logic        last;
} timer_res_t;

class timer_scoreboard;
	logic [31:0] dl [HeapDepth];
	logic [15:0] iv [HeapDepth];
	logic [15:0] tid [HeapDepth];
	int          cnt;
	logic [31:0] ticks;
	logic [15:0] nid;
	timer_res_t  pending [$];
	int          errors;

	function new();
		cnt = 0; ticks = 0; nid = 0; errors = 0;
	endfunction

	// signed distance of a deadline from the current tick
	function automatic int rel(logic [31:0] d);
		logic [31:0] r;
		r = d - ticks;
		return $signed(r);
	endfunction

	function automatic bit goes_first(int a, int b);
		if (rel(dl[a]) != rel(dl[b])) return rel(dl[a]) < rel(dl[b]);
		return tid[a] < tid[b];
	endfunction

	function automatic void push(timer_res_t r);
		pending.push_back(r);
	endfunction

	// predict the results of one accepted request
	function automatic void note_request(logic req, logic [15:0] ival);
		int k, best;
		logic [15:0] v;
		v = (ival == 0) ? 16'd1 : ival;
		if (req == REQ_ADD) begin
			if (cnt >= HeapDepth) begin
				push('{KIND_FULL, 16'd0, 1'b1});
			end else begin
				dl[cnt] = ticks + v; iv[cnt] = v; tid[cnt] = nid; cnt++;
				push('{KIND_ACCEPT, nid, 1'b1});
				nid++;
			end
			return;
		end
		ticks++;
		k = 0;
		while (cnt > 0 && k < MaxExp) begin
			best = 0;
			for (int i = 1; i < cnt; i++)
				if (goes_first(i, best)) best = i;
			if (rel(dl[best]) > 0) break;
			push('{KIND_EXPIRED, tid[best], 1'b0});
			k++;
			dl[best] = ticks + iv[best];
		end
		push('{KIND_DONE, 16'd0, 1'b1});
	endfunction

	function automatic void check_result(logic [1:0] kind, logic [15:0] id, logic last);
		timer_res_t e;
		if (pending.size() == 0) begin
			$error("unexpected result kind=%0d id=%0d", kind, id);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (kind !== e.kind) begin
			$error("result_kind exp %0d got %0d", e.kind, kind); errors++;
		end
		if (id !== e.id) begin
			$error("timer_num exp %0d got %0d", e.id, id); errors++;
		end
		if (last !== e.last) begin
			$error("last exp %0d got %0d", e.last, last); errors++;
		end
	endfunction
endclass

module testbench;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	timer_scoreboard sb = new();
	bit quiet = 0;  // no idling in the final stretch
	bit stim_done = 0;

	always #2 clk = ~clk;

	periodic_timer_heap_core u_dut (.*);

	// receiver: random stall bursts, check every transfer
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 0;
				gap = $urandom_range(1, 13);
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[1:0], m_axis_tdata[17:2], m_axis_tlast);

	// called at a falling edge; tvalid stays high after a transfer so that
	// back-to-back requests see a single update per edge
	task automatic send_request(logic req, logic [15:0] ival);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= ival;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(req, ival);
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_request(REQ_TICK, 16'($urandom));
	endtask

	initial begin
		int n;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: tick on empty queue, zero and extreme intervals, ties,
		// overflow to full, then ticks with several timers due at once
		send_tick();
		send_request(REQ_ADD, 16'd0);
		send_request(REQ_ADD, 16'hFFFF);
		send_request(REQ_ADD, 16'd1);
		send_request(REQ_ADD, 16'd2);
		send_request(REQ_ADD, 16'd1);
		send_request(REQ_ADD, 16'd1);
		send_request(REQ_ADD, 16'd3);
		send_request(REQ_ADD, 16'd1);
		send_request(REQ_ADD, 16'd5);
		send_request(REQ_ADD, 16'hAAAA);
		repeat (6) send_tick();
		// random: mostly ticks with short-period timers so expiries are frequent
		n = 0;
		while (n < 230) begin
			if (n == 200) quiet = 1;
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0: send_request(REQ_ADD, 16'($urandom));
					1: send_request(REQ_ADD, 16'hFFFF);
					default: send_request(REQ_ADD, 16'($urandom_range(0, 6)));
				endcase
			end else begin
				send_tick();
			end
			n++;
			// id wrap is not reachable in this run
		end
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
